// ----- sv/tlb_page_table_translator_assert.svh -----
// Assertion macros used by the checker file tpt_checker.sv.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH

// a implies b at the same edge
`define TPT_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// a implies b at the next edge
`define TPT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ----- sv/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpt_pkg
// Widths, sizes and the queue word shared by the translator's parts.
// ----------------------------------------------------------------------------
package tpt_pkg;
   localparam int PAGE_BITS   = 8;
   localparam int FRAME_BITS  = 7;
   localparam int OFFSET_BITS = 8;
   localparam int TLB_ENTRIES = 16;
   localparam int ADDR_BITS   = 16;
   localparam int PHYS_BITS   = 15;
   localparam int CNT_BITS    = 32;
   localparam int NUM_PAGES   = 1 << PAGE_BITS;
   localparam int NUM_FRAMES  = 1 << FRAME_BITS;
   localparam int SLOT_BITS   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int Q_DEPTH     = 2;

   // word passed from lookup front end to table back end
   typedef struct packed {
      logic [PAGE_BITS-1:0]   page;
      logic [OFFSET_BITS-1:0] offset;
      logic                   hit;
      logic [FRAME_BITS-1:0]  frame;
   } lookup_type;

   // TLB update request from back end
   typedef struct packed {
      logic                  ins;
      logic [PAGE_BITS-1:0]  ins_page;
      logic [FRAME_BITS-1:0] ins_frame;
      logic                  drop;
      logic [PAGE_BITS-1:0]  drop_page;
   } tlb_upd_type;
endpackage

// ----- sv/tpt_front.sv -----
// ----------------------------------------------------------------------------
// tpt_front
// Accepts addresses, searches the TLB and classifies each as hit or miss.
// Holds the TLB; updates come from the back end.
// ----------------------------------------------------------------------------
module tpt_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tpt_pkg::ADDR_BITS-1:0]     req_logical_address,
   output logic                              lk_valid,
   input  logic                              lk_ready,
   output tpt_pkg::lookup_type               lk_word,
   input  tpt_pkg::tlb_upd_type              upd,
   input  logic                              idle
);
   logic [tpt_pkg::PAGE_BITS-1:0]  tlb_page_ff  [tpt_pkg::TLB_ENTRIES];
   logic [tpt_pkg::FRAME_BITS-1:0] tlb_frame_ff [tpt_pkg::TLB_ENTRIES];
   logic [tpt_pkg::TLB_ENTRIES-1:0] tlb_valid_ff;
   logic [tpt_pkg::SLOT_BITS-1:0]  slot_ff;
   logic [tpt_pkg::PAGE_BITS-1:0]  page;
   logic                           hit;
   logic [tpt_pkg::FRAME_BITS-1:0] hframe;

   // one item in flight: lookup waits until back end has updated the TLB
   assign req_ready = idle && lk_ready;
   assign page = req_logical_address[tpt_pkg::OFFSET_BITS +: tpt_pkg::PAGE_BITS];

   always_comb begin
      hit = 1'b0;
      hframe = '0;
      for (int i = tpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && tlb_page_ff[i] == page) begin
            hit = 1'b1;
            hframe = tlb_frame_ff[i];
         end
      end
   end

   assign lk_valid = req_valid && req_ready;
   always_comb begin
      lk_word.page   = page;
      lk_word.offset = req_logical_address[tpt_pkg::OFFSET_BITS-1:0];
      lk_word.hit    = hit;
      lk_word.frame  = hframe;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff <= '0;
         slot_ff <= '0;
      end else begin
         for (int i = 0; i < tpt_pkg::TLB_ENTRIES; i++) begin
            if (upd.drop && tlb_valid_ff[i] && tlb_page_ff[i] == upd.drop_page)
               tlb_valid_ff[i] <= 1'b0;
         end
         if (upd.ins) begin
            tlb_page_ff[slot_ff]  <= upd.ins_page;
            tlb_frame_ff[slot_ff] <= upd.ins_frame;
            tlb_valid_ff[slot_ff] <= 1'b1;
            if (32'(slot_ff) == tpt_pkg::TLB_ENTRIES - 1) slot_ff <= '0;
            else slot_ff <= slot_ff + 1'b1;
         end
      end
   end
endmodule

// ----- sv/tpt_queue.sv -----
// ----------------------------------------------------------------------------
// tpt_queue
// Short FIFO of lookup words between front end and back end.
// ----------------------------------------------------------------------------
module tpt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tpt_pkg::lookup_type in_word,
   output logic                out_valid,
   input  logic                out_ready,
   output tpt_pkg::lookup_type out_word
);
   tpt_pkg::lookup_type mem_ff [tpt_pkg::Q_DEPTH];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != 2'(tpt_pkg::Q_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_word  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            mem_ff[wp_ff] <= in_word;
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ----- sv/tpt_back.sv -----
// ----------------------------------------------------------------------------
// tpt_back
// Resolves misses against the page table, assigns frames in FIFO order,
// updates the TLB and counters and holds the result word.
// ----------------------------------------------------------------------------
module tpt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  tpt_pkg::lookup_type               q_word,
   output tpt_pkg::tlb_upd_type              upd,
   output logic                              busy,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tpt_pkg::PHYS_BITS-1:0]     rsp_physical_address,
   output logic [tpt_pkg::FRAME_BITS-1:0]    rsp_frame_number,
   output logic                              rsp_tlb_hit,
   output logic                              rsp_page_fault,
   output logic                              rsp_evicted_valid,
   output logic [tpt_pkg::PAGE_BITS-1:0]     rsp_evicted_page,
   output logic [tpt_pkg::CNT_BITS-1:0]      rsp_access_count,
   output logic [tpt_pkg::CNT_BITS-1:0]      rsp_miss_count,
   output logic [tpt_pkg::CNT_BITS-1:0]      rsp_fault_count
);
   typedef enum logic [2:0] {
      S_IDLE, S_PT, S_OWN, S_OWNCHK, S_DONE
   } state_type;

   state_type state_ff;
   logic [tpt_pkg::FRAME_BITS-1:0] pmap_mem [tpt_pkg::NUM_PAGES];
   logic [tpt_pkg::NUM_PAGES-1:0]  present_ff;
   logic [tpt_pkg::PAGE_BITS-1:0]  owner_mem [tpt_pkg::NUM_FRAMES];
   logic [tpt_pkg::FRAME_BITS-1:0] pmap_rd_ff, next_frame_ff;
   logic [tpt_pkg::PAGE_BITS-1:0]  owner_rd_ff;
   logic                           all_used_ff;
   tpt_pkg::lookup_type            cur_ff;
   logic [tpt_pkg::CNT_BITS-1:0]   acc_ff, miss_ff, flt_ff;
   logic                           out_v_ff;
   logic [tpt_pkg::FRAME_BITS-1:0] frame_ff;
   logic                           fault_ff, ev_v_ff;
   logic [tpt_pkg::PAGE_BITS-1:0]  ev_page_ff;
   tpt_pkg::tlb_upd_type           upd_ff;

   assign q_ready = state_ff == S_IDLE && !out_v_ff;
   assign busy = state_ff != S_IDLE || out_v_ff;
   assign upd = upd_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_frame_number = frame_ff;
   assign rsp_physical_address =
      tpt_pkg::PHYS_BITS'({frame_ff, cur_ff.offset});
   assign rsp_tlb_hit = cur_ff.hit;
   assign rsp_page_fault = fault_ff;
   assign rsp_evicted_valid = ev_v_ff;
   assign rsp_evicted_page = ev_page_ff;
   assign rsp_access_count = acc_ff;
   assign rsp_miss_count = miss_ff;
   assign rsp_fault_count = flt_ff;

   // memories: registered reads
   always_ff @(posedge clock) begin
      pmap_rd_ff  <= pmap_mem[cur_ff.page];
      owner_rd_ff <= owner_mem[next_frame_ff];
      if (state_ff == S_OWNCHK && !present_ff[cur_ff.page]) begin
         pmap_mem[cur_ff.page]    <= next_frame_ff;
         owner_mem[next_frame_ff] <= cur_ff.page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         present_ff <= '0;
         next_frame_ff <= '0;
         all_used_ff <= 1'b0;
         acc_ff <= '0;
         miss_ff <= '0;
         flt_ff <= '0;
         out_v_ff <= 1'b0;
         upd_ff <= '0;
      end else begin
         upd_ff <= '0;
         if (out_v_ff && rsp_ready) out_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid && q_ready) begin
                  cur_ff <= q_word;
                  acc_ff <= acc_ff + 1'b1;
                  fault_ff <= 1'b0;
                  ev_v_ff <= 1'b0;
                  ev_page_ff <= '0;
                  frame_ff <= q_word.frame;
                  if (q_word.hit) state_ff <= S_DONE;
                  else begin
                     miss_ff <= miss_ff + 1'b1;
                     state_ff <= S_PT;
                  end
               end
            end
            S_PT: begin
               state_ff <= S_OWN; // memory reads settle
            end
            S_OWN: begin
               if (present_ff[cur_ff.page]) begin
                  frame_ff <= pmap_rd_ff;
                  upd_ff.ins <= 1'b1;
                  upd_ff.ins_page <= cur_ff.page;
                  upd_ff.ins_frame <= pmap_rd_ff;
                  state_ff <= S_DONE;
               end else state_ff <= S_OWNCHK;
            end
            S_OWNCHK: begin
               // fault: reuse next frame, evict its owner if still mapped
               if (all_used_ff && present_ff[owner_rd_ff]
                   && owner_rd_ff != cur_ff.page) begin
                  ev_v_ff <= 1'b1;
                  ev_page_ff <= owner_rd_ff;
                  upd_ff.drop <= 1'b1;
                  upd_ff.drop_page <= owner_rd_ff;
               end
               present_ff[cur_ff.page] <= 1'b1;
               if (all_used_ff && present_ff[owner_rd_ff]
                   && owner_rd_ff != cur_ff.page)
                  present_ff[owner_rd_ff] <= 1'b0;
               frame_ff <= next_frame_ff;
               fault_ff <= 1'b1;
               flt_ff <= flt_ff + 1'b1;
               upd_ff.ins <= 1'b1;
               upd_ff.ins_page <= cur_ff.page;
               upd_ff.ins_frame <= next_frame_ff;
               next_frame_ff <= next_frame_ff + 1'b1;
               if (&next_frame_ff) all_used_ff <= 1'b1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- sv/tlb_page_table_translator.sv -----
// Flow: an accepted address passes through the queue into the back end; a TLB hit
// goes on to S_DONE, a miss to a present page through S_PT and S_OWN, and a page
// fault through S_PT, S_OWN and S_OWNCHK before S_DONE registers the result.
// Throughput: one address at a time, set by the page-table read-modify-write and idle
// handoff; the next is accepted only after the result word is taken and idle is set.
// Reset: synchronous, clears TLB valid bits, page present bits, frame pointer and counters.
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical translation through a TLB and a FIFO-replaced page table.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tpt_pkg::ADDR_BITS-1:0]     req_logical_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tpt_pkg::PHYS_BITS-1:0]     rsp_physical_address,
   output logic [tpt_pkg::FRAME_BITS-1:0]    rsp_frame_number,
   output logic                              rsp_tlb_hit,
   output logic                              rsp_page_fault,
   output logic                              rsp_evicted_valid,
   output logic [tpt_pkg::PAGE_BITS-1:0]     rsp_evicted_page,
   output logic [tpt_pkg::CNT_BITS-1:0]      rsp_access_count,
   output logic [tpt_pkg::CNT_BITS-1:0]      rsp_miss_count,
   output logic [tpt_pkg::CNT_BITS-1:0]      rsp_fault_count
);
   logic lk_valid, lk_ready, q_valid, q_ready, busy, q_push, idle_ff;
   tpt_pkg::lookup_type lk_word, q_word;
   tpt_pkg::tlb_upd_type upd;

   // idle: no word queued or in the back end, and no TLB update pending
   always_ff @(posedge clock) begin
      if (reset) idle_ff <= 1'b1;
      else idle_ff <= !busy && !q_valid && !q_push && !(lk_valid && lk_ready)
                      && !(q_valid && q_ready);
   end
   assign q_push = lk_valid && lk_ready;

   tpt_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_logical_address,
      .lk_valid, .lk_ready, .lk_word, .upd, .idle(idle_ff && !busy && !q_valid)
   );

   tpt_queue u_queue (
      .clock, .reset, .in_valid(lk_valid), .in_ready(lk_ready), .in_word(lk_word),
      .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
   );

   tpt_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_word, .upd, .busy,
      .rsp_valid, .rsp_ready, .rsp_physical_address, .rsp_frame_number,
      .rsp_tlb_hit, .rsp_page_fault, .rsp_evicted_valid, .rsp_evicted_page,
      .rsp_access_count, .rsp_miss_count, .rsp_fault_count
   );
endmodule

// ----- sv/tpt_checker.sv -----
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks on the translator's result words.
// ----------------------------------------------------------------------------
`include "tlb_page_table_translator_assert.svh"
module tpt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_tlb_hit,
   input logic                           rsp_page_fault,
   input logic                           rsp_evicted_valid,
   input logic [tpt_pkg::PAGE_BITS-1:0]  rsp_evicted_page,
   input logic [tpt_pkg::CNT_BITS-1:0]   rsp_miss_count,
   input logic [tpt_pkg::CNT_BITS-1:0]   rsp_fault_count
);
   `TPT_ASSERT_IMP(hit_no_fault, clock, reset, rsp_valid && rsp_tlb_hit, !rsp_page_fault)
   `TPT_ASSERT_IMP(evict_needs_fault, clock, reset, rsp_valid && rsp_evicted_valid, rsp_page_fault)
   `TPT_ASSERT_IMP(no_evict_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)
   `TPT_ASSERT_NEXT(hold_stall, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_miss_count) && $stable(rsp_fault_count))
endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_tlb_hit, .rsp_page_fault,
   .rsp_evicted_valid, .rsp_evicted_page, .rsp_miss_count, .rsp_fault_count
);

// ----- tb/sv/tlb_page_table_translator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_checker
// Watches both channels, keeps its own TLB / page-table image and compares
// every returned word with the predicted translation.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [tpt_pkg::ADDR_BITS-1:0]     req_logical_address,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [tpt_pkg::PHYS_BITS-1:0]     rsp_physical_address,
   input  logic [tpt_pkg::FRAME_BITS-1:0]    rsp_frame_number,
   input  logic                              rsp_tlb_hit,
   input  logic                              rsp_page_fault,
   input  logic                              rsp_evicted_valid,
   input  logic [tpt_pkg::PAGE_BITS-1:0]     rsp_evicted_page,
   input  logic [tpt_pkg::CNT_BITS-1:0]      rsp_access_count,
   input  logic [tpt_pkg::CNT_BITS-1:0]      rsp_miss_count,
   input  logic [tpt_pkg::CNT_BITS-1:0]      rsp_fault_count,
   output int                                errors,
   output int                                pending,
   output int                                hits_seen,
   output int                                faults_seen,
   output int                                evictions_seen
);
   typedef struct packed {
      logic [tpt_pkg::PHYS_BITS-1:0]  phys;
      logic [tpt_pkg::FRAME_BITS-1:0] frame;
      logic                           hit;
      logic                           fault;
      logic                           ev_valid;
      logic [tpt_pkg::PAGE_BITS-1:0]  ev_page;
      logic [tpt_pkg::CNT_BITS-1:0]   accesses;
      logic [tpt_pkg::CNT_BITS-1:0]   misses;
      logic [tpt_pkg::CNT_BITS-1:0]   faults;
   } xlate_type;

   logic [tpt_pkg::PAGE_BITS-1:0]  tlb_pg [tpt_pkg::TLB_ENTRIES];
   logic [tpt_pkg::FRAME_BITS-1:0] tlb_fr [tpt_pkg::TLB_ENTRIES];
   logic                           tlb_ok [tpt_pkg::TLB_ENTRIES];
   logic [tpt_pkg::FRAME_BITS-1:0] pt_frame [tpt_pkg::NUM_PAGES];
   logic                           pt_present [tpt_pkg::NUM_PAGES];
   logic [tpt_pkg::PAGE_BITS-1:0]  owner [tpt_pkg::NUM_FRAMES];
   logic [tpt_pkg::FRAME_BITS-1:0] frame_ptr;
   logic                           wrapped;
   logic [tpt_pkg::SLOT_BITS-1:0]  slot_ptr;
   logic [tpt_pkg::CNT_BITS-1:0]   n_acc, n_miss, n_fault;
   xlate_type                      expected_xlates[$];

   function automatic xlate_type translate(logic [tpt_pkg::ADDR_BITS-1:0] addr);
      xlate_type r;
      logic [tpt_pkg::PAGE_BITS-1:0] pg;
      logic [tpt_pkg::FRAME_BITS-1:0] fr;
      logic [tpt_pkg::PAGE_BITS-1:0] old;
      r = '0;
      pg = addr[tpt_pkg::OFFSET_BITS +: tpt_pkg::PAGE_BITS];
      fr = '0;
      n_acc++;
      for (int i = 0; i < tpt_pkg::TLB_ENTRIES; i++)
         if (!r.hit && tlb_ok[i] && tlb_pg[i] == pg) begin
            r.hit = 1'b1;
            fr = tlb_fr[i];
         end
      if (!r.hit) begin
         n_miss++;
         if (!pt_present[pg]) begin
            fr = frame_ptr;
            if (wrapped) begin
               old = owner[fr];
               if (pt_present[old] && pt_frame[old] == fr) begin
                  pt_present[old] = 1'b0;
                  for (int i = 0; i < tpt_pkg::TLB_ENTRIES; i++)
                     if (tlb_ok[i] && tlb_pg[i] == old) tlb_ok[i] = 1'b0;
                  r.ev_valid = 1'b1;
                  r.ev_page = old;
               end
            end
            frame_ptr = fr + 1'b1;
            if (frame_ptr == 0) wrapped = 1'b1;
            pt_frame[pg] = fr;
            pt_present[pg] = 1'b1;
            owner[fr] = pg;
            n_fault++;
            r.fault = 1'b1;
         end
         fr = pt_frame[pg];
         tlb_pg[slot_ptr] = pg;
         tlb_fr[slot_ptr] = fr;
         tlb_ok[slot_ptr] = 1'b1;
         slot_ptr = (slot_ptr == tpt_pkg::TLB_ENTRIES - 1) ? '0 : slot_ptr + 1'b1;
      end
      r.frame = fr;
      r.phys = tpt_pkg::PHYS_BITS'({fr, addr[tpt_pkg::OFFSET_BITS-1:0]});
      r.accesses = n_acc;
      r.misses = n_miss;
      r.faults = n_fault;
      return r;
   endfunction

   always @(posedge clock) begin
      xlate_type got, want;
      if (reset) begin
         foreach (tlb_ok[i]) tlb_ok[i] = 1'b0;
         foreach (pt_present[i]) pt_present[i] = 1'b0;
         frame_ptr = '0;
         wrapped = 1'b0;
         slot_ptr = '0;
         n_acc = '0;
         n_miss = '0;
         n_fault = '0;
         expected_xlates.delete();
         errors = 0;
         hits_seen = 0;
         faults_seen = 0;
         evictions_seen = 0;
      end else begin
         if (req_valid && req_ready)
            expected_xlates.push_back(translate(req_logical_address));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_physical_address, rsp_frame_number, rsp_tlb_hit, rsp_page_fault,
                    rsp_evicted_valid, rsp_evicted_page, rsp_access_count,
                    rsp_miss_count, rsp_fault_count};
            hits_seen += got.hit;
            faults_seen += got.fault;
            evictions_seen += got.ev_valid;
            if (expected_xlates.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word: %p", got);
            end else begin
               want = expected_xlates.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
               end
            end
         end
      end
      pending = expected_xlates.size();
   end
endmodule

// ----- tb/sv/tlb_page_table_translator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_test
// Drives directed and random addresses with random gaps and stalls through
// the translator; the checker predicts every word and counts mismatches.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_test;
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [tpt_pkg::ADDR_BITS-1:0]   req_logical_address = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [tpt_pkg::PHYS_BITS-1:0]   rsp_physical_address;
   logic [tpt_pkg::FRAME_BITS-1:0]  rsp_frame_number;
   logic                            rsp_tlb_hit, rsp_page_fault, rsp_evicted_valid;
   logic [tpt_pkg::PAGE_BITS-1:0]   rsp_evicted_page;
   logic [tpt_pkg::CNT_BITS-1:0]    rsp_access_count, rsp_miss_count, rsp_fault_count;
   int                              errors, pending, hits_seen, faults_seen, evictions_seen;
   int                              words_sent = 0;
   int                              rsp_wait = 0;
   bit                              hold_rsp = 1'b0;
   bit                              rsp_hold_done = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   tlb_page_table_translator dut (.*);

   tlb_page_table_translator_checker checker_i (.*);

   // valid stays up after the accept edge; the next call either drops it
   // for a gap or reloads it with the next address
   task automatic send_address(logic [tpt_pkg::ADDR_BITS-1:0] addr);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_logical_address <= addr;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // wait until every expected word has come back
   task automatic drain();
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // pages drawn mostly from a working set so hits, refaults and reuse all occur
   function automatic logic [tpt_pkg::ADDR_BITS-1:0] pick_address(int span);
      logic [tpt_pkg::PAGE_BITS-1:0] pg;
      pg = (span >= tpt_pkg::NUM_PAGES) ? tpt_pkg::PAGE_BITS'($urandom)
                                        : tpt_pkg::PAGE_BITS'($urandom_range(0, span - 1));
      return {pg, tpt_pkg::OFFSET_BITS'($urandom)};
   endfunction

   // receiver: drops ready for a random wait after each word, plus one long hold
   always @(posedge clock) begin
      int w;
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_ready && rsp_valid) begin
         w = $urandom_range(0, 16);
         rsp_ready <= (w == 0);
         rsp_wait <= (w == 0) ? 0 : w - 1;
      end else if (rsp_wait != 0) rsp_wait <= rsp_wait - 1;
      else rsp_ready <= 1'b1;
   end

   initial begin
      int span;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, repeat hit, neighbours
      send_address(16'h0000);
      send_address(16'h0000);
      send_address(16'hFFFF);
      send_address(16'hFF00);
      send_address(16'h00FF);
      send_address(16'hAA55);
      send_address(16'h55AA);
      send_address(16'h0001);
      for (int i = 1; i <= 17; i++) send_address({tpt_pkg::PAGE_BITS'(i), 8'h80});
      send_address(16'h0000);
      // long receiver hold while items keep coming
      hold_rsp = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_hold_done = 1'b1;
         end
         begin
            for (int i = 0; i < 20; i++) send_address(pick_address(40));
            req_valid <= 1'b0;
         end
      join
      drain();
      for (int i = 0; i < 1700; i++) begin
         case (i / 300)
            0: span = 12;
            1: span = 24;
            2: span = 140;
            default: span = tpt_pkg::NUM_PAGES;
         endcase
         send_address(pick_address(span));
         if (i == 850) begin
            req_valid <= 1'b0;
            drain();
         end
      end
      req_valid <= 1'b0;
      drain();
      repeat (20) @(posedge clock);
      $display("sent %0d addresses: %0d tlb hits, %0d faults, %0d evictions",
               words_sent, hits_seen, faults_seen, evictions_seen);
      if (errors == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule

// ----- tlb_page_table_translator.f -----
+incdir+sv
sv/tpt_pkg.sv
sv/tpt_front.sv
sv/tpt_queue.sv
sv/tpt_back.sv
sv/tlb_page_table_translator.sv
sv/tpt_checker.sv
tb/sv/tlb_page_table_translator_checker.sv
tb/sv/tlb_page_table_translator_test.sv
